/* hdl/pls_pkg.sv */
// Package for the positional list store: payload structs, request and status codes,
// sequencer states and the memory control struct.
// Depends on nothing; every other file in hdl uses it by scoped names.
package pls_pkg;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [5:0]  position;
      logic [31:0] data_in;
   } pls_req_type;

   typedef struct packed {
      logic [31:0] data_out;
      logic [1:0]  status;
      logic [5:0]  count;
   } pls_rsp_type;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      PLS_IDLE,
      PLS_SHIFT,
      PLS_RESP
   } pls_state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } pls_ram_ctl_type;

endpackage

/* hdl/pls_ram.sv */
// Entry storage for the positional list store: one write port and one read port
// with registered read data. Depends on pls_pkg for the control struct.
module pls_ram #(
   parameter int DEPTH      = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic                        clock,
   input  pls_pkg::pls_ram_ctl_type    ctl,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [DATA_WIDTH-1:0]       wr_data,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [DATA_WIDTH-1:0]       rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/positional_list_store_unit.sv */
// Top level of the positional list store: request checks, entry count, shift sequencer
// and result register. Depends on pls_pkg and instantiates pls_ram.
//
// The block keeps an ordered list of up to DEPTH words in a single-port-write,
// single-port-read memory. Each request item inserts a word at a position from 0 to
// the current count, reads the word at a position, or deletes it; exactly one result
// item comes back carrying the word read or removed (zero otherwise), a status (ok,
// position out of range or list empty, list full) and the count after the request.
// Entries are moved one per cycle by a small sequencer that shares a single address
// counter and the memory ports, so timing depends on how many entries move. A rejected
// request goes from the idle state straight to the result state; an accepted one passes
// through the shift state first. An insert moves (count - position) entries, none when
// the word goes on the end, and a delete moves (count - position - 1) entries, where
// count is the size before the request.
// The shift loop, one memory read and one memory write per cycle, sets how long it takes.
// The block takes one item at a time and is ready again as soon as the result has
// been placed in the output register, so a new item may be accepted while the
// previous result still waits to be taken; the next result then waits until the
// output register is free.
// There is no clearing pass after reset: only entries below the count are ever read.
module positional_list_store_unit #(
   parameter int DEPTH      = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pls_pkg::pls_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pls_pkg::pls_rsp_type rsp_data
);

   // Address width, count width (holds DEPTH itself) and a compare width that covers
   // both the count and the request position.
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 6) ? CW : 6;

   pls_pkg::pls_state_type state_ff, state_in;

   logic [CW-1:0]         occ_ff, occ_in;
   logic [CW-1:0]         cur_ff, cur_in;
   logic [CW-1:0]         lim_ff, lim_in;
   logic                  is_insert_ff, is_insert_in;
   logic                  is_delete_ff, is_delete_in;
   logic                  pend_ff, pend_in;
   logic                  first_ff, first_in;
   logic [AW-1:0]         wa_ff, wa_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [DATA_WIDTH-1:0] got_ff, got_in;
   pls_pkg::pls_rsp_type  res_ff, res_in;
   pls_pkg::pls_rsp_type  rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;

   pls_pkg::pls_ram_ctl_type ram_ctl;
   logic [AW-1:0]            ram_wr_addr;
   logic [DATA_WIDTH-1:0]    ram_wr_data;
   logic [AW-1:0]            ram_rd_addr;
   logic [DATA_WIDTH-1:0]    ram_rd_data;

   logic [XW-1:0] pos_x;
   logic [XW-1:0] occ_x;
   logic [CW-1:0] cur_dec;

   assign pos_x   = XW'(req_data.position);
   assign occ_x   = XW'(occ_ff);
   assign cur_dec = cur_ff - CW'(1);

   pls_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pls_pkg::PLS_IDLE;
         occ_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of the sequencer and the result path.
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      lim_ff       <= lim_in;
      is_insert_ff <= is_insert_in;
      is_delete_ff <= is_delete_in;
      first_ff     <= first_in;
      wa_ff        <= wa_in;
      word_ff      <= word_in;
      got_ff       <= got_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   // Sequencer. An insert walks down from the count to the position, moving each
   // entry up by one place, and then writes the new word. A delete walks up from the
   // position, keeping the first word read and moving the rest down by one place. A
   // read is a delete that stops after its first word. Reads are pipelined: the word
   // read in one cycle is written in the next, while the following read is issued.
   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      cur_in       = cur_ff;
      lim_in       = lim_ff;
      is_insert_in = is_insert_ff;
      is_delete_in = is_delete_ff;
      pend_in      = pend_ff;
      first_in     = first_ff;
      wa_in        = wa_ff;
      word_in      = word_ff;
      got_in       = got_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_load     = 1'b0;
      req_ready    = 1'b0;
      ram_ctl      = '0;
      ram_wr_addr  = wa_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = cur_ff[AW-1:0];

      unique case (state_ff)
         pls_pkg::PLS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_in.data_out = '0;
               res_in.status   = pls_pkg::STATUS_RANGE;
               res_in.count    = 6'(occ_ff);
               pend_in         = 1'b0;
               first_in        = 1'b1;
               word_in         = DATA_WIDTH'(req_data.data_in);
               got_in          = '0;
               state_in        = pls_pkg::PLS_RESP;
               unique case (req_data.req_type) inside
                  pls_pkg::OP_INSERT: begin
                     if (pos_x > occ_x) begin
                        res_in.status = pls_pkg::STATUS_RANGE;
                     end else if (occ_ff == CW'(DEPTH)) begin
                        res_in.status = pls_pkg::STATUS_FULL;
                     end else begin
                        is_insert_in = 1'b1;
                        is_delete_in = 1'b0;
                        cur_in       = occ_ff;
                        lim_in       = CW'(req_data.position);
                        state_in     = pls_pkg::PLS_SHIFT;
                     end
                  end
                  pls_pkg::OP_READ, pls_pkg::OP_DELETE: begin
                     if (pos_x < occ_x) begin
                        is_insert_in = 1'b0;
                        is_delete_in = (req_data.req_type == pls_pkg::OP_DELETE);
                        cur_in       = CW'(req_data.position);
                        lim_in       = (req_data.req_type == pls_pkg::OP_DELETE) ?
                                       (occ_ff - CW'(1)) : CW'(req_data.position);
                        state_in     = pls_pkg::PLS_SHIFT;
                     end
                  end
                  default: begin
                     res_in.status = pls_pkg::STATUS_RANGE;
                  end
               endcase
            end
         end

         pls_pkg::PLS_SHIFT: begin
            if (is_insert_ff) begin
               ram_rd_addr = cur_dec[AW-1:0];
               if (pend_ff) begin
                  ram_ctl.wr_en = 1'b1;
               end
               if (cur_ff > lim_ff) begin
                  ram_ctl.rd_en = 1'b1;
                  pend_in       = 1'b1;
                  wa_in         = cur_ff[AW-1:0];
                  cur_in        = cur_dec;
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     // The gap is open: place the new word and finish.
                     ram_ctl.wr_en   = 1'b1;
                     ram_wr_addr     = lim_ff[AW-1:0];
                     ram_wr_data     = word_ff;
                     occ_in          = occ_ff + CW'(1);
                     res_in.data_out = '0;
                     res_in.status   = pls_pkg::STATUS_OK;
                     res_in.count    = 6'(occ_in);
                     state_in        = pls_pkg::PLS_RESP;
                  end
               end
            end else begin
               if (pend_ff) begin
                  if (first_ff) begin
                     got_in   = ram_rd_data;
                     first_in = 1'b0;
                  end else begin
                     ram_ctl.wr_en = 1'b1;
                  end
               end
               if (cur_ff <= lim_ff) begin
                  ram_ctl.rd_en = 1'b1;
                  pend_in       = 1'b1;
                  wa_in         = cur_dec[AW-1:0];
                  cur_in        = cur_ff + CW'(1);
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     if (is_delete_ff) begin
                        occ_in = occ_ff - CW'(1);
                     end
                     res_in.data_out = 32'(got_ff);
                     res_in.status   = pls_pkg::STATUS_OK;
                     res_in.count    = 6'(occ_in);
                     state_in        = pls_pkg::PLS_RESP;
                  end
               end
            end
         end

         pls_pkg::PLS_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               rsp_in   = res_ff;
               state_in = pls_pkg::PLS_IDLE;
            end
         end

         default: begin
            state_in = pls_pkg::PLS_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
